// File: src/rse_pkg.sv
// Shared types, constants and helpers of the RPN stack evaluator.
`default_nettype none

package rse_pkg;

  // Token codes carried on the command field; code 7 is unused.
  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_SUB   = 3'd2,
    CMD_MUL   = 3'd3,
    CMD_DIV   = 3'd4,
    CMD_MOD   = 3'd5,
    CMD_PRINT = 3'd6
  } cmd_e;

  // Status codes; a higher code takes precedence.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_DIVZERO = 2'd3
  } status_e;

  localparam int unsigned DataW   = 32;
  localparam int unsigned FracW   = 16;
  localparam int unsigned QuoW    = DataW + FracW;
  localparam int unsigned CntW    = 6;
  localparam logic [CntW-1:0] DivSteps = CntW'(QuoW);
  localparam logic [CntW-1:0] ModSteps = CntW'(FracW);

  localparam logic [DataW-1:0] MaxPos = 32'h7fff_ffff;
  localparam logic [DataW-1:0] MinNeg = 32'h8000_0000;
  localparam logic signed [63:0] MulRound = 64'sd32768;

  // Magnitude of a signed word; the most negative value maps to 2^31.
  function automatic logic [DataW-1:0] abs32(input logic signed [DataW-1:0] v);
    return v[DataW-1] ? (~v + 32'd1) : v;
  endfunction

endpackage

`default_nettype wire

// File: src/rse_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module rse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: src/rpn_stack_evaluator.sv
// Top level of the RPN stack evaluator: sequencer, stack memory and arithmetic.
`default_nettype none

// The evaluator takes one token per input transaction (push, add, subtract,
// multiply, divide, modulo or print) and returns exactly one output
// transaction for each, carrying the printed value, a printed flag and a
// status code. Operands are signed Q16.16 words held in a stack memory of
// STACK_DEPTH entries with a registered read. Tokens are handled one at
// a time because each depends on the stack left by the one before. A push
// writes its operand directly; a print pops one operand; the other tokens
// pop a right and then a left operand, compute, and push the result. A
// multiply first registers the full product. Divide and modulo use a shared
// restoring divider that resolves one quotient bit per cycle, 48 bits for a
// Q16.16 quotient and 16 for the integer remainder; a zero divisor skips the
// left pop and the divider. A finished result sits in an output register,
// so the next transaction can be accepted while the previous result waits
// to be taken.
// Products are rounded to nearest (ties upwards) and saturated; quotients
// are truncated towards zero and saturated. Popping an empty stack yields
// zero and reports stack empty, a push onto a full stack is dropped and
// reports stack full, and a zero divisor is discarded with divide by zero
// reported and nothing pushed. There is no clearing pass: stack entries
// are only ever used after they have been written.
module rpn_stack_evaluator
  import rse_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic        [2:0]       command_i,
  input  wire logic signed [31:0]      operand_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed      [31:0]      value_o,
  output logic                         printed_o,
  output logic             [1:0]       status_o
);

  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned SpW   = $clog2(STACK_DEPTH + 1);
  localparam logic [SpW-1:0] SpMax = SpW'(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_RIGHT,
    S_LEFT,
    S_MUL,
    S_DIV,
    S_DIVFIN,
    S_PUSH,
    S_OUT
  } state_e;

  state_e                   state_q;
  cmd_e                     cmd_q;
  logic signed [DataW-1:0]  operand_q;
  logic        [SpW-1:0]    sp_q;
  status_e                  status_q;
  logic signed [DataW-1:0]  print_val_q;
  logic                     pop_empty_q;
  logic signed [DataW-1:0]  right_q;
  logic signed [DataW-1:0]  res_q;
  logic signed [63:0]       prod_q;
  logic        [QuoW-1:0]   div_quo_q;
  logic        [DataW-1:0]  div_rem_q;
  logic        [DataW-1:0]  div_dsr_q;
  logic        [CntW-1:0]   div_cnt_q;
  logic                     neg_q;
  logic                     out_valid_q;
  logic signed [DataW-1:0]  value_q;
  logic                     printed_q;
  status_e                  out_status_q;

  // Stack memory ports.
  logic                     ram_we;
  logic        [AddrW-1:0]  ram_waddr;
  logic        [DataW-1:0]  ram_wdata;
  logic        [AddrW-1:0]  ram_raddr;
  logic        [DataW-1:0]  ram_rdata;

  logic                     sp_full;
  logic                     sp_zero;
  logic signed [DataW-1:0]  pop_data;
  logic        [DataW-1:0]  pop_abs;
  logic        [DataW-1:0]  right_abs;
  logic signed [63:0]       mul_full;
  logic signed [DataW:0]    add_sum;
  logic signed [DataW:0]    sub_diff;
  logic signed [DataW-1:0]  add_sat;
  logic signed [DataW-1:0]  sub_sat;
  logic signed [63:0]       mul_rounded;
  logic signed [47:0]       mul_shifted;
  logic signed [DataW-1:0]  mul_sat;
  logic        [DataW:0]    rem_shift;
  logic        [DataW+1:0]  trial;
  logic                     trial_ge;
  logic        [DataW-1:0]  quo_res;
  logic        [DataW-1:0]  mod_mag;
  logic        [DataW-1:0]  div_res;

  assign sp_full  = (sp_q == SpMax);
  assign sp_zero  = (sp_q == '0);

  // The sequencer never reads and writes the same entry in one cycle: a pop
  // and a push of one token always fall in different states, so no
  // forwarding is needed. The read port follows the top of stack at all
  // times, and each pop consumes the data in the cycle after it was addressed.
  assign ram_raddr = AddrW'(sp_q - SpW'(1));
  assign ram_waddr = sp_q[AddrW-1:0];
  assign ram_wdata = (state_q == S_PUSH) ? res_q : operand_q;
  assign ram_we    = !sp_full &&
                     ((state_q == S_PUSH) || (state_q == S_START && cmd_q == CMD_PUSH));

  rse_ram #(
    .WIDTH(DataW),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // A pop from an empty stack reads as zero.
  assign pop_data  = pop_empty_q ? '0 : $signed(ram_rdata);
  assign pop_abs   = abs32(pop_data);
  assign right_abs = abs32(right_q);

  // Saturating add and subtract on the popped left operand.
  assign add_sum  = {pop_data[DataW-1], pop_data} + {right_q[DataW-1], right_q};
  assign sub_diff = {pop_data[DataW-1], pop_data} - {right_q[DataW-1], right_q};
  assign add_sat  = (add_sum[DataW] != add_sum[DataW-1]) ?
                    (add_sum[DataW] ? MinNeg : MaxPos) : add_sum[DataW-1:0];
  assign sub_sat  = (sub_diff[DataW] != sub_diff[DataW-1]) ?
                    (sub_diff[DataW] ? MinNeg : MaxPos) : sub_diff[DataW-1:0];

  // Multiply, then round and saturate from the registered product.
  assign mul_full    = pop_data * right_q;
  assign mul_rounded = prod_q + MulRound;
  assign mul_shifted = 48'(mul_rounded >>> FracW);
  assign mul_sat     = (mul_shifted > 48'sh0000_7fff_ffff) ? MaxPos :
                       (mul_shifted < -48'sh0000_8000_0000) ? MinNeg :
                       mul_shifted[DataW-1:0];

  // One restoring divider step: shift in the next dividend bit and subtract.
  assign rem_shift = {div_rem_q, div_quo_q[QuoW-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, div_dsr_q};
  assign trial_ge  = !trial[DataW+1];

  // Signed, saturated quotient and the remainder scaled back to Q16.16.
  assign quo_res = neg_q ?
                   ((div_quo_q > QuoW'(MinNeg)) ? MinNeg : (~div_quo_q[DataW-1:0] + 32'd1)) :
                   ((div_quo_q > QuoW'(MaxPos)) ? MaxPos : div_quo_q[DataW-1:0]);
  assign mod_mag = {div_rem_q[FracW-1:0], {FracW{1'b0}}};
  assign div_res = (cmd_q == CMD_MOD) ?
                   (neg_q ? (~mod_mag + 32'd1) : mod_mag) : quo_res;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign printed_o   = printed_q;
  assign status_o    = out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // The output state loads the next result itself, so the register is
      // only emptied here while no new result is being loaded.
      if (out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q       <= cmd_e'(command_i);
            operand_q   <= operand_i;
            status_q    <= ST_OK;
            print_val_q <= '0;
            state_q     <= S_START;
          end
        end
        S_START: begin
          case (cmd_q)
            CMD_PUSH: begin
              if (sp_full) begin
                status_q <= ST_FULL;
              end else begin
                sp_q <= sp_q + SpW'(1);
              end
              state_q <= S_OUT;
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_PRINT: begin
              // Pop the right operand, or the only operand of a print.
              pop_empty_q <= sp_zero;
              if (sp_zero) begin
                status_q <= ST_EMPTY;
              end else begin
                sp_q <= sp_q - SpW'(1);
              end
              state_q <= S_RIGHT;
            end
            default: begin
              state_q <= S_OUT;
            end
          endcase
        end
        S_RIGHT: begin
          right_q <= pop_data;
          if (cmd_q == CMD_PRINT) begin
            print_val_q <= pop_data;
            state_q     <= S_OUT;
          end else if ((cmd_q == CMD_DIV && pop_data == '0) ||
                       (cmd_q == CMD_MOD && pop_abs[DataW-1:FracW] == '0)) begin
            // The divisor stays popped; the left operand is left in place.
            status_q <= ST_DIVZERO;
            state_q  <= S_OUT;
          end else begin
            pop_empty_q <= sp_zero;
            if (sp_zero) begin
              status_q <= ST_EMPTY;
            end else begin
              sp_q <= sp_q - SpW'(1);
            end
            state_q <= S_LEFT;
          end
        end
        S_LEFT: begin
          div_rem_q <= '0;
          case (cmd_q)
            CMD_ADD: begin
              res_q   <= add_sat;
              state_q <= S_PUSH;
            end
            CMD_SUB: begin
              res_q   <= sub_sat;
              state_q <= S_PUSH;
            end
            CMD_MUL: begin
              prod_q  <= mul_full;
              state_q <= S_MUL;
            end
            CMD_DIV: begin
              div_quo_q <= {pop_abs, {FracW{1'b0}}};
              div_dsr_q <= right_abs;
              div_cnt_q <= DivSteps;
              neg_q     <= pop_data[DataW-1] ^ right_q[DataW-1];
              state_q   <= S_DIV;
            end
            CMD_MOD: begin
              div_quo_q <= {pop_abs[DataW-1:FracW], {DataW{1'b0}}};
              div_dsr_q <= {{FracW{1'b0}}, right_abs[DataW-1:FracW]};
              div_cnt_q <= ModSteps;
              neg_q     <= pop_data[DataW-1];
              state_q   <= S_DIV;
            end
            default: begin
              state_q <= S_OUT;
            end
          endcase
        end
        S_MUL: begin
          res_q   <= mul_sat;
          state_q <= S_PUSH;
        end
        S_DIV: begin
          div_rem_q <= trial_ge ? trial[DataW-1:0] : rem_shift[DataW-1:0];
          div_quo_q <= {div_quo_q[QuoW-2:0], trial_ge};
          div_cnt_q <= div_cnt_q - CntW'(1);
          if (div_cnt_q == CntW'(1)) begin
            state_q <= S_DIVFIN;
          end
        end
        S_DIVFIN: begin
          res_q   <= div_res;
          state_q <= S_PUSH;
        end
        S_PUSH: begin
          if (sp_full) begin
            status_q <= ST_FULL;
          end else begin
            sp_q <= sp_q + SpW'(1);
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            value_q      <= print_val_q;
            printed_q    <= (cmd_q == CMD_PRINT);
            out_status_q <= status_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The stack pointer never runs past the memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni) sp_q <= SpMax)
    else $error("stack pointer beyond stack depth");

  // Pushing a result always finds room, since two pops came first.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (state_q == S_PUSH) |-> !sp_full)
    else $error("result push onto a full stack");

  // A new result only appears from the output state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside the output state");

  // A printed result can only report ok or stack empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && printed_q) |->
                   (out_status_q == ST_OK || out_status_q == ST_EMPTY))
    else $error("printed result with an impossible status");
`endif

endmodule

`default_nettype wire

// File: verif/rpn_stack_evaluator_tb.sv
// Self-checking testbench of the RPN stack evaluator: directed tokens, then shaped random ones.
`default_nettype none

module rpn_stack_evaluator_tb
  import rse_pkg::*;
();

  localparam int unsigned StackDepth   = 128;
  localparam int unsigned RandomItems  = 320;
  localparam int unsigned PressureItems = 24;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned StallLimit   = 4000;

  typedef struct packed {
    logic signed [31:0] value;
    logic               printed;
    status_e            status;
  } token_result_t;

  // One row of the directed table; the typed result is used instead of the
  // prediction where the outcome is obvious from the token alone.
  typedef struct {
    cmd_e               cmd;
    logic signed [31:0] operand;
    bit                 typed;
    token_result_t      want;
  } stim_row_t;

  // Random stream shaping: ordinary arithmetic, a run of pushes past the
  // top of the stack, and the run of pops that brings it back down.
  typedef enum logic [1:0] {
    SHAPE_NORMAL,
    SHAPE_FILL,
    SHAPE_DRAIN
  } shape_e;

  localparam token_result_t SilentOk = '{32'sh0, 1'b0, ST_OK};
  localparam int unsigned DirectedRows = 26;

  stim_row_t directed_rows [DirectedRows] = '{
    '{CMD_PRINT, 32'sh0,         1'b1, '{32'sh0, 1'b1, ST_EMPTY}},
    '{CMD_SUB,   32'sh0,         1'b1, '{32'sh0, 1'b0, ST_EMPTY}},
    '{CMD_PRINT, 32'sh0,         1'b1, '{32'sh0, 1'b1, ST_OK}},
    '{CMD_DIV,   32'sh0,         1'b1, '{32'sh0, 1'b0, ST_DIVZERO}},
    '{CMD_PUSH,  MaxPos,         1'b1, SilentOk},
    '{CMD_PUSH,  MaxPos,         1'b1, SilentOk},
    '{CMD_ADD,   32'sh0,         1'b1, SilentOk},
    '{CMD_PRINT, 32'sh0,         1'b1, '{MaxPos, 1'b1, ST_OK}},
    '{CMD_PUSH,  MinNeg,         1'b1, SilentOk},
    '{CMD_PUSH,  MinNeg,         1'b1, SilentOk},
    '{CMD_MUL,   32'sh0,         1'b1, SilentOk},
    '{CMD_PRINT, 32'sh0,         1'b1, '{MaxPos, 1'b1, ST_OK}},
    '{CMD_PUSH,  32'shFFF8_8000, 1'b1, SilentOk},
    '{CMD_PUSH,  32'sh0002_4000, 1'b1, SilentOk},
    '{CMD_MOD,   32'sh0,         1'b1, SilentOk},
    '{CMD_PRINT, 32'sh0,         1'b1, '{32'shFFFF_0000, 1'b1, ST_OK}},
    '{CMD_PUSH,  32'sh0005_0000, 1'b1, SilentOk},
    '{CMD_PUSH,  32'sh0000_8000, 1'b1, SilentOk},
    '{CMD_MOD,   32'sh0,         1'b1, '{32'sh0, 1'b0, ST_DIVZERO}},
    '{CMD_PUSH,  32'shFFFF_FFFF, 1'b0, SilentOk},
    '{CMD_DIV,   32'sh1234_5678, 1'b0, SilentOk},
    '{CMD_PRINT, 32'sh7FFF_FFFF, 1'b0, SilentOk},
    '{CMD_PUSH,  32'shFFFF_FFFF, 1'b0, SilentOk},
    '{CMD_PUSH,  32'sh0000_8000, 1'b0, SilentOk},
    '{CMD_MUL,   32'sh0,         1'b0, SilentOk},
    '{CMD_PRINT, 32'sh8000_0000, 1'b0, SilentOk}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [2:0] command_i = CMD_PUSH;
  logic signed [31:0] operand_i = 32'sh0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic signed [31:0] value_o;
  logic printed_o;
  logic [1:0] status_o;

  // Shadow copy of the operand stack.
  logic signed [31:0] eval_stack [StackDepth];
  int unsigned eval_depth = 0;
  status_e eval_status = ST_OK;

  token_result_t expected_results [$];
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  shape_e token_shape = SHAPE_NORMAL;
  int unsigned overflow_left = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  rpn_stack_evaluator #(
    .STACK_DEPTH(StackDepth)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .operand_i  (operand_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o),
    .printed_o  (printed_o),
    .status_o   (status_o)
  );

  always #6 clk_i = ~clk_i;

  // The worst condition seen while handling one token is the one reported.
  function automatic void lift_status(status_e s);
    if (s > eval_status) eval_status = s;
  endfunction

  function automatic longint pop_operand();
    if (eval_depth > 0) begin
      eval_depth--;
      return longint'(eval_stack[eval_depth]);
    end
    lift_status(ST_EMPTY);
    return 0;
  endfunction

  function automatic void push_operand(longint v);
    if (eval_depth < StackDepth) begin
      eval_stack[eval_depth] = 32'(v);
      eval_depth++;
    end else begin
      lift_status(ST_FULL);
    end
  endfunction

  function automatic longint saturate_word(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
    if (v < longint'(32'sh8000_0000)) return longint'(32'sh8000_0000);
    return v;
  endfunction

  // Applies one token to the shadow stack and returns the result it gives.
  function automatic token_result_t evaluate_token(logic [2:0] cmd,
                                                   logic signed [31:0] opnd);
    token_result_t r;
    longint lhs;
    longint rhs;
    eval_status = ST_OK;
    r.value = 32'sh0;
    r.printed = 1'b0;
    case (cmd)
      CMD_PUSH: push_operand(longint'(opnd));
      CMD_ADD: begin
        rhs = pop_operand();
        lhs = pop_operand();
        push_operand(saturate_word(lhs + rhs));
      end
      CMD_SUB: begin
        rhs = pop_operand();
        lhs = pop_operand();
        push_operand(saturate_word(lhs - rhs));
      end
      CMD_MUL: begin
        rhs = pop_operand();
        lhs = pop_operand();
        // Arithmetic shift floors, so adding a half first rounds ties upwards.
        push_operand(saturate_word((lhs * rhs + 64'sd32768) >>> 16));
      end
      CMD_DIV: begin
        rhs = pop_operand();
        if (rhs == 0) begin
          lift_status(ST_DIVZERO);
        end else begin
          lhs = pop_operand();
          push_operand(saturate_word((lhs * 65536) / rhs));
        end
      end
      CMD_MOD: begin
        // Integer parts truncate towards zero; the remainder follows the left sign.
        rhs = pop_operand() / 65536;
        if (rhs == 0) begin
          lift_status(ST_DIVZERO);
        end else begin
          lhs = pop_operand() / 65536;
          push_operand((lhs % rhs) * 65536);
        end
      end
      CMD_PRINT: begin
        r.value = 32'(pop_operand());
        r.printed = 1'b1;
      end
      default: ;
    endcase
    r.status = eval_status;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3: begin
        case ($urandom_range(4))
          0: return MaxPos;
          1: return MinNeg;
          2: return 32'sh0001_0000;
          3: return -32'sh1;
          default: return 32'sh1;
        endcase
      end
      4: return 32'sh0;
      5: return {16'($urandom), 16'h0};
      // Magnitude at most one half, so its integer part is zero.
      6: return 32'($signed(16'($urandom)));
      default: return 32'($urandom_range(20'hF_FFFF)) - 32'sh0008_0000;
    endcase
  endfunction

  // Offers one token, waits for its transaction and records what it should
  // produce. Valid is left high so that a following token goes straight on.
  task automatic send_token(input logic [2:0] cmd, input logic signed [31:0] opnd,
                            input bit typed, input token_result_t want);
    token_result_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    operand_i <= opnd;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = evaluate_token(cmd, opnd);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic send_random_token();
    logic [2:0] cmd;
    int unsigned pick;
    pick = $urandom_range(99);
    case (token_shape)
      SHAPE_FILL: begin
        cmd = CMD_PUSH;
        if (eval_depth == StackDepth) begin
          overflow_left--;
          if (overflow_left == 0) token_shape = SHAPE_DRAIN;
        end
      end
      SHAPE_DRAIN: begin
        cmd = 3'($urandom_range(CMD_ADD, CMD_PRINT));
        if (eval_depth <= 5) token_shape = SHAPE_NORMAL;
      end
      default: begin
        // Mostly well-formed expressions, with a little noise that may pop
        // an empty stack.
        if (pick < 8) cmd = 3'($urandom_range(CMD_PUSH, CMD_PRINT));
        else if (eval_depth < 2 || (eval_depth < 10 && pick < 45)) cmd = CMD_PUSH;
        else cmd = 3'($urandom_range(CMD_ADD, CMD_PRINT));
      end
    endcase
    send_token(cmd, pick_operand(), 1'b0, '0);
  endtask

  // Result checker and receiver-side ready generation.
  always @(posedge clk_i) begin
    token_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected: value %h status %0d",
               value_o, status_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (value_o !== want.value) begin
          $error("value: expected %h, got %h", want.value, value_o);
          error_count++;
        end
        if (printed_o !== want.printed) begin
          $error("printed: expected %b, got %b", want.printed, printed_o);
          error_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
      end
    end
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: too long without any transaction on either side ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("rpn_stack_evaluator_tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_token(directed_rows[i].cmd, directed_rows[i].operand,
                 directed_rows[i].typed, directed_rows[i].want);

    // The receiver holds off while tokens keep coming, so the output
    // register fills and the input side has to stall.
    hold_toggle <= ~hold_toggle;
    repeat (PressureItems) send_random_token();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (RandomItems) send_random_token();

    send_idle_pct = 57;
    recv_stall_pct = 0;
    repeat (RandomItems) send_random_token();

    send_idle_pct = 0;
    recv_stall_pct = 57;
    repeat (RandomItems) send_random_token();

    // Last phase runs the stack past full and back down again.
    send_idle_pct = 26;
    recv_stall_pct = 26;
    token_shape = SHAPE_FILL;
    overflow_left = 4;
    repeat (RandomItems) send_random_token();

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0) $display("rpn_stack_evaluator_tb: clean");
    else $display("rpn_stack_evaluator_tb: errors");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
src/rse_pkg.sv
src/rse_ram.sv
src/rpn_stack_evaluator.sv
verif/rpn_stack_evaluator_tb.sv
